// ===== hdl/fim_pkg.sv =====
`default_nettype none
package fim_pkg;

  localparam int WINDOW_DEPTH  = 64;
  localparam int STAMP_BITS    = 48;

  localparam int TS_BITS       = 48;
  localparam int AVG_BITS      = 32;
  localparam int RATE_BITS     = 16;
  localparam int TPS_BITS      = 32;
  localparam int HEAD_BITS     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_BITS     = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_BITS      = AVG_BITS + $clog2(WINDOW_DEPTH);
  localparam int SPAN_BITS     = TPS_BITS + 1;
  localparam int DIV_CNT_BITS  = $clog2(SUM_BITS + 1);

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  // register index, taken from the word address bit
  localparam logic REG_TICKS_PER_SECOND = 1'b0;
  localparam logic [TPS_BITS-1:0] TPS_RESET = 32'd10_000_000;

  localparam logic [AVG_BITS-1:0]  INTERVAL_MAX = '1;
  localparam logic [RATE_BITS-1:0] RATE_MAX     = '1;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_TICK  = 2'd0;
  localparam cmd_t CMD_STOP  = 2'd1;
  localparam cmd_t CMD_START = 2'd2;
  localparam cmd_t CMD_RESET = 2'd3;

  typedef logic [STAMP_BITS-1:0] stamp_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic decode;
    logic check;
    logic window;
    logic div_go;
    logic total;
    logic load_out;
  } fim_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic run_tick;
    logic fill_nz;
    logic div_done;
  } fim_stat_t;

endpackage
`default_nettype wire

// ===== hdl/fim_if.sv =====
`default_nettype none
interface fim_in_if import fim_pkg::*; ();
  logic                 valid;
  logic                 ready;
  cmd_t                 command;
  logic [TS_BITS-1:0]   timestamp;

  modport source (output valid, command, timestamp, input ready);
  modport sink   (input valid, command, timestamp, output ready);
endinterface

interface fim_out_if import fim_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [AVG_BITS-1:0]  average_frame_ticks;
  logic [RATE_BITS-1:0] frame_rate;
  logic [TS_BITS-1:0]   total_ticks;
  logic                 is_stopped;

  modport source (output valid, average_frame_ticks, frame_rate, total_ticks, is_stopped,
                  input ready);
  modport sink   (input valid, average_frame_ticks, frame_rate, total_ticks, is_stopped,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/fim_ram.sv =====
`default_nettype none
module fim_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [ABITS-1:0] waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [ABITS-1:0] raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/fim_div.sv =====
`default_nettype none
module fim_div import fim_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [SUM_BITS-1:0]  dividend,
  input  wire logic [FILL_BITS-1:0] divisor,
  output logic                      done,
  output logic      [SUM_BITS-1:0]  quotient
);

  localparam int REM_BITS = FILL_BITS + 1;

  logic                    busy_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic [SUM_BITS-1:0]     q_r;
  logic [REM_BITS-1:0]     rem_r;
  logic [FILL_BITS-1:0]    dvs_r;
  logic [REM_BITS-1:0]     trial;
  logic                    fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_r[REM_BITS-2:0], q_r[SUM_BITS-1]};
    fits  = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_BITS'(SUM_BITS);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r && (cnt_r != '0)) begin
      q_r   <= {q_r[SUM_BITS-2:0], fits};
      rem_r <= fits ? (trial - {1'b0, dvs_r}) : trial;
    end
  end

  assign done     = busy_r && (cnt_r == '0);
  assign quotient = q_r;

endmodule
`default_nettype wire

// ===== hdl/fim_ctrl.sv =====
`default_nettype none
module fim_ctrl import fim_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire fim_stat_t stat,
  output fim_ctl_t       ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_WINDOW = 3'd3;
  localparam logic [2:0] S_DIVGO  = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_TOTAL  = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctl           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl.decode = 1'b1;
        state_nxt  = stat.run_tick ? S_CHECK : S_TOTAL;
      end
      S_CHECK: begin
        ctl.check = 1'b1;
        state_nxt = S_WINDOW;
      end
      S_WINDOW: begin
        ctl.window = 1'b1;
        state_nxt  = S_DIVGO;
      end
      S_DIVGO: begin
        ctl.div_go = 1'b1;
        state_nxt  = stat.fill_nz ? S_DIV : S_TOTAL;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_TOTAL;
        end
      end
      S_TOTAL: begin
        ctl.total = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          ctl.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted transaction did not enter decode");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !stat.div_done) |=> (state_r == S_DIV))
    else $error("left divide before the quotient was ready");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && slot_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not presented after completion");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |-> slot_free)
    else $error("result register overwritten while still pending");

endmodule
`default_nettype wire

// ===== hdl/fim_dp.sv =====
`default_nettype none
module fim_dp import fim_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fim_ctl_t             ctl,
  output fim_stat_t                 stat,
  input  wire cmd_t                 in_command,
  input  wire logic [TS_BITS-1:0]   in_timestamp,
  input  wire logic [TPS_BITS-1:0]  ticks_per_second,
  output logic      [AVG_BITS-1:0]  out_average,
  output logic      [RATE_BITS-1:0] out_rate,
  output logic      [TS_BITS-1:0]   out_total,
  output logic                      out_stopped
);

  // captured transaction
  cmd_t                 cmd_r;
  stamp_t               ts_r;

  // timer state
  stamp_t               last_r;
  stamp_t               cur_r;
  stamp_t               base_r;
  stamp_t               paused_r;
  stamp_t               stop_r;
  logic                 stopped_r;

  // window and rate state
  logic [FILL_BITS-1:0] fill_r;
  logic [HEAD_BITS-1:0] head_r, head_nxt;
  logic [SUM_BITS-1:0]  sum_r, sum_nxt;
  logic [AVG_BITS-1:0]  avg_r;
  logic [RATE_BITS-1:0] frames_r;
  logic [SPAN_BITS-1:0] span_r;
  logic [RATE_BITS-1:0] rate_r;

  // per-tick scratch
  logic [AVG_BITS-1:0]  interval_r;
  logic                 take_r;
  stamp_t               total_r;

  stamp_t               delta;
  logic [AVG_BITS-1:0]  interval_sat;
  logic [AVG_BITS-1:0]  avg_dist;
  logic                 full;
  logic                 run_tick;
  logic [AVG_BITS-1:0]  old_val;
  logic                 ram_we;
  logic                 div_start;
  logic                 div_done;
  logic [SUM_BITS-1:0]  quotient;

  always_comb begin
    run_tick     = (cmd_r == CMD_TICK) && !stopped_r;
    delta        = ts_r - last_r;
    interval_sat = (delta > stamp_t'(INTERVAL_MAX)) ? INTERVAL_MAX : delta[AVG_BITS-1:0];
    avg_dist     = (interval_r >= avg_r) ? (interval_r - avg_r) : (avg_r - interval_r);
    full         = (fill_r == FILL_BITS'(WINDOW_DEPTH));
    sum_nxt      = sum_r + SUM_BITS'(interval_r) - (full ? SUM_BITS'(old_val) : '0);
    head_nxt     = (head_r == HEAD_BITS'(WINDOW_DEPTH - 1)) ? '0 : head_r + 1'b1;
    ram_we       = ctl.window && take_r;
    div_start    = ctl.div_go && (fill_r != '0);
  end

  assign stat.run_tick = run_tick;
  assign stat.fill_nz  = (fill_r != '0);
  assign stat.div_done = div_done;

  fim_ram #(
    .WIDTH (AVG_BITS),
    .DEPTH (WINDOW_DEPTH),
    .ABITS (HEAD_BITS)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (interval_r),
    .raddr (head_r),
    .rdata (old_val)
  );

  fim_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (fill_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r    <= '0;
      cur_r     <= '0;
      base_r    <= '0;
      paused_r  <= '0;
      stop_r    <= '0;
      stopped_r <= 1'b0;
      fill_r    <= '0;
      head_r    <= '0;
      sum_r     <= '0;
      avg_r     <= '0;
      frames_r  <= '0;
      span_r    <= '0;
      rate_r    <= '0;
    end else begin
      if (ctl.decode) begin
        if (run_tick) begin
          cur_r  <= ts_r;
          last_r <= ts_r;
        end else begin
          case (cmd_r)
            CMD_TICK: begin
              avg_r <= '0;
            end
            CMD_STOP: begin
              if (!stopped_r) begin
                stop_r    <= ts_r;
                stopped_r <= 1'b1;
              end
            end
            CMD_START: begin
              if (stopped_r) begin
                paused_r  <= paused_r + (ts_r - stop_r);
                last_r    <= ts_r;
                stop_r    <= '0;
                stopped_r <= 1'b0;
              end
            end
            default: begin
              base_r    <= ts_r;
              last_r    <= ts_r;
              stop_r    <= '0;
              stopped_r <= 1'b0;
            end
          endcase
        end
      end

      if (ctl.check) begin
        if (frames_r != RATE_MAX) begin
          frames_r <= frames_r + 1'b1;
        end
        span_r <= span_r + SPAN_BITS'(interval_r);
      end

      if (ctl.window) begin
        if (take_r) begin
          sum_r  <= sum_nxt;
          head_r <= head_nxt;
          if (!full) begin
            fill_r <= fill_r + 1'b1;
          end
        end
        if (span_r > SPAN_BITS'(ticks_per_second)) begin
          rate_r   <= frames_r;
          frames_r <= '0;
          span_r   <= '0;
        end
      end

      if (ctl.div_go && (fill_r == '0)) begin
        avg_r <= '0;
      end else if (div_done) begin
        avg_r <= quotient[AVG_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= in_command;
      ts_r  <= stamp_t'(in_timestamp);
    end
    if (ctl.decode) begin
      interval_r <= interval_sat;
    end
    if (ctl.check) begin
      take_r <= (avg_dist < ticks_per_second);
    end
    if (ctl.total) begin
      total_r <= (stopped_r ? stop_r : cur_r) - paused_r - base_r;
    end
    if (ctl.load_out) begin
      out_average <= avg_r;
      out_rate    <= rate_r;
      out_total   <= TS_BITS'(total_r);
      out_stopped <= stopped_r;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/frame_interval_meter.sv =====
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    command, timestamp
// out_ch   out  valid/ready    average_frame_ticks, frame_rate, total_ticks, is_stopped
// cfg      in   APB, pready=1  ticks_per_second at byte address 0
//
// Stop, start, reset and ticks while stopped pass decode and total before the result.
// A running tick adds check and window steps and, for a nonempty window, waits for the
// bit-serial divider that produces one quotient bit per cycle over the 38-bit window sum.
// One transaction is in flight at a time; the next is accepted while a result is pending.
// A stalled output holds the result register and delays only the completion step.
// Reset is synchronous; the interval window needs no clearing pass.
`default_nettype none
module frame_interval_meter import fim_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  fim_in_if.sink                        in_ch,
  fim_out_if.source                     out_ch,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output logic      [CFG_DATA_BITS-1:0] prdata,
  output logic                          pready
);

  logic [TPS_BITS-1:0] tps_r;
  logic                reg_sel;
  fim_ctl_t            ctl;
  fim_stat_t           stat;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_TICKS_PER_SECOND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      tps_r <= pwdata[TPS_BITS-1:0];
    end
  end

  assign prdata = reg_sel ? CFG_DATA_BITS'(tps_r) : '0;

  fim_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  fim_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .stat             (stat),
    .in_command       (in_ch.command),
    .in_timestamp     (in_ch.timestamp),
    .ticks_per_second (tps_r),
    .out_average      (out_ch.average_frame_ticks),
    .out_rate         (out_ch.frame_rate),
    .out_total        (out_ch.total_ticks),
    .out_stopped      (out_ch.is_stopped)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
module tb_top;
  import fim_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PRINT_CAP    = 40;
  localparam logic [CFG_ADDR_BITS-1:0] TPS_ADDR = {REG_TICKS_PER_SECOND, 2'b00};

  typedef struct {
    cmd_t   cmd;
    stamp_t ts;
  } meter_cmd_t;

  typedef struct {
    logic [AVG_BITS-1:0]  avg;
    logic [RATE_BITS-1:0] rate;
    logic [TS_BITS-1:0]   total;
    logic                 stopped;
  } meter_reading_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // stimulus side
  logic                     drv_valid  = 1'b0;
  cmd_t                     drv_cmd    = CMD_TICK;
  logic [TS_BITS-1:0]       drv_ts     = '0;
  logic                     sink_ready = 1'b1;
  logic                     apb_sel    = 1'b0;
  logic                     apb_en     = 1'b0;
  logic                     apb_wr     = 1'b0;
  logic [CFG_ADDR_BITS-1:0] apb_addr   = '0;
  logic [CFG_DATA_BITS-1:0] apb_wdata  = '0;
  wire  [CFG_DATA_BITS-1:0] apb_rdata;
  wire                      apb_ready;

  fim_in_if  in_if ();
  fim_out_if out_if ();

  assign in_if.valid     = drv_valid;
  assign in_if.command   = drv_cmd;
  assign in_if.timestamp = drv_ts;
  assign out_if.ready    = sink_ready;

  frame_interval_meter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (apb_sel),
    .penable (apb_en),
    .pwrite  (apb_wr),
    .paddr   (apb_addr),
    .pwdata  (apb_wdata),
    .prdata  (apb_rdata),
    .pready  (apb_ready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  meter_cmd_t     command_queue[$];
  meter_reading_t pending_readings[$];

  int unsigned cycle_count = 0;
  int unsigned err_count   = 0;
  bit          in_taken    = 1'b0;
  bit          calm        = 1'b0;
  int unsigned src_gap     = 0;
  int unsigned src_mode    = 1;
  int unsigned sink_hold   = 0;
  int unsigned sink_mode   = 1;

  // predicted meter state
  logic [TPS_BITS-1:0]  meter_tps = TPS_RESET;
  stamp_t               last_stamp = '0;
  stamp_t               cur_stamp  = '0;
  stamp_t               base_stamp = '0;
  stamp_t               paused_sum = '0;
  stamp_t               stop_stamp = '0;
  logic                 halted     = 1'b0;
  logic [AVG_BITS-1:0]  win_mem [WINDOW_DEPTH];
  int unsigned          win_fill   = 0;
  int unsigned          win_head   = 0;
  logic [SUM_BITS-1:0]  win_sum    = '0;
  logic [AVG_BITS-1:0]  avg_ticks  = '0;
  logic [RATE_BITS-1:0] span_frames = '0;
  logic [SPAN_BITS-1:0] span_len   = '0;
  logic [RATE_BITS-1:0] held_rate  = '0;

  // stimulus generator's view of the timeline
  stamp_t gen_mark   = '0;
  stamp_t gen_stop   = '0;
  bit     gen_halted = 1'b0;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  task automatic advance_meter(input cmd_t c, input stamp_t ts);
    stamp_t              delta;
    logic [AVG_BITS-1:0] iv;
    logic [AVG_BITS-1:0] dev;
    meter_reading_t      rd;
    case (c)
      CMD_TICK: begin
        if (halted) begin
          avg_ticks = '0;
        end else begin
          cur_stamp = ts;
          delta = ts - last_stamp;
          iv = (delta[TS_BITS-1:AVG_BITS] != '0) ? INTERVAL_MAX : delta[AVG_BITS-1:0];
          last_stamp = ts;
          dev = (iv >= avg_ticks) ? iv - avg_ticks : avg_ticks - iv;
          if (dev < meter_tps) begin
            if (win_fill >= WINDOW_DEPTH) win_sum = win_sum - win_mem[win_head];
            else win_fill++;
            win_mem[win_head] = iv;
            win_sum = win_sum + iv;
            win_head = (win_head + 1) % WINDOW_DEPTH;
          end
          if (span_frames != RATE_MAX) span_frames++;
          span_len = span_len + iv;
          if (span_len > meter_tps) begin
            held_rate   = span_frames;
            span_frames = '0;
            span_len    = '0;
          end
          avg_ticks = (win_fill != 0) ? AVG_BITS'(win_sum / win_fill) : '0;
        end
      end
      CMD_STOP: begin
        if (!halted) begin
          stop_stamp = ts;
          halted     = 1'b1;
        end
      end
      CMD_START: begin
        if (halted) begin
          paused_sum = paused_sum + ts - stop_stamp;
          last_stamp = ts;
          stop_stamp = '0;
          halted     = 1'b0;
        end
      end
      default: begin
        base_stamp = ts;
        last_stamp = ts;
        stop_stamp = '0;
        halted     = 1'b0;
      end
    endcase
    rd.avg     = avg_ticks;
    rd.rate    = held_rate;
    rd.total   = (halted ? stop_stamp : cur_stamp) - paused_sum - base_stamp;
    rd.stopped = halted;
    pending_readings.push_back(rd);
  endtask

  // input acceptance, result check, watchdog
  always @(posedge clk) begin
    meter_reading_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("frame_interval_meter: mismatch");
      $finish;
    end else if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        advance_meter(in_if.command, in_if.timestamp);
        in_taken = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_readings.size() == 0) begin
          report_mismatch("result with no transaction outstanding",
                          out_if.average_frame_ticks, 0);
        end else begin
          want = pending_readings.pop_front();
          if (out_if.average_frame_ticks !== want.avg)
            report_mismatch("average_frame_ticks", out_if.average_frame_ticks, want.avg);
          if (out_if.frame_rate !== want.rate)
            report_mismatch("frame_rate", out_if.frame_rate, want.rate);
          if (out_if.total_ticks !== want.total)
            report_mismatch("total_ticks", out_if.total_ticks, want.total);
          if (out_if.is_stopped !== want.stopped)
            report_mismatch("is_stopped", out_if.is_stopped, want.stopped);
        end
      end
    end
  end

  // command driver
  always @(negedge clk) begin
    meter_cmd_t itm;
    logic       nv;
    if (cycle_count % 256 == 0) src_mode = $urandom_range(0, 2);
    nv = drv_valid;
    if (rst_n && (!drv_valid || in_taken)) begin
      in_taken = 1'b0;
      nv = 1'b0;
      if (src_gap != 0) begin
        src_gap--;
      end else if (!calm && src_mode != 0 &&
                   $urandom_range(0, (src_mode == 1) ? 7 : 2) == 0) begin
        src_gap = $urandom_range(0, 5);
      end else if (command_queue.size() != 0) begin
        itm = command_queue.pop_front();
        drv_cmd <= itm.cmd;
        drv_ts  <= itm.ts;
        nv = 1'b1;
      end
    end
    drv_valid <= nv;
  end

  // result backpressure
  always @(negedge clk) begin
    logic nr;
    if (cycle_count % 256 == 128) sink_mode = $urandom_range(0, 2);
    nr = 1'b1;
    if (sink_hold != 0) begin
      sink_hold--;
      nr = 1'b0;
    end else if (!calm && sink_mode != 0 &&
                 $urandom_range(0, (sink_mode == 1) ? 7 : 2) == 0) begin
      sink_hold = $urandom_range(0, 5);
      nr = 1'b0;
    end
    sink_ready <= nr;
  end

  task automatic write_tps(input logic [TPS_BITS-1:0] value);
    @(negedge clk);
    apb_sel   <= 1'b1;
    apb_en    <= 1'b0;
    apb_wr    <= 1'b1;
    apb_addr  <= TPS_ADDR;
    apb_wdata <= value;
    @(negedge clk);
    apb_en <= 1'b1;
    do @(posedge clk); while (!apb_ready);
    meter_tps = value;
    // read it back
    @(negedge clk);
    apb_en <= 1'b0;
    apb_wr <= 1'b0;
    @(negedge clk);
    apb_en <= 1'b1;
    do @(posedge clk); while (!apb_ready);
    if (apb_rdata !== value) report_mismatch("ticks_per_second readback", apb_rdata, value);
    @(negedge clk);
    apb_sel <= 1'b0;
    apb_en  <= 1'b0;
  endtask

  task automatic drain();
    while (command_queue.size() != 0 || drv_valid || pending_readings.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_cmd(input cmd_t c, input stamp_t ts);
    meter_cmd_t itm;
    itm.cmd = c;
    itm.ts  = ts;
    command_queue.push_back(itm);
  endtask

  // Mostly ticks whose interval sits near the running average, so the window
  // fills and rolls; the rest are outliers, pauses, resets and raw noise.
  task automatic pick_command(output meter_cmd_t itm);
    int unsigned       r;
    longint unsigned   a;
    longint unsigned   tps;
    longint unsigned   half;
    longint unsigned   iv;
    r    = $urandom_range(0, 99);
    a    = avg_ticks;
    tps  = meter_tps;
    half = (tps > 1) ? (tps - 1) / 2 : 0;
    itm.cmd = CMD_TICK;
    itm.ts  = gen_mark;
    if (r >= 96) begin
      itm.cmd = cmd_t'($urandom_range(0, 3));
      itm.ts  = {16'($urandom), 32'($urandom)};
    end else if (gen_halted) begin
      if (r < 55) begin
        itm.cmd = CMD_START;
        itm.ts  = gen_stop + $urandom_range(0, 100_000);
      end else if (r < 80) begin
        itm.ts  = gen_stop + $urandom_range(0, 1000);
      end else if (r < 92) begin
        itm.cmd = CMD_STOP;
        itm.ts  = gen_stop + $urandom_range(0, 1000);
      end else begin
        itm.cmd = CMD_RESET;
        itm.ts  = gen_stop + $urandom_range(0, 1000);
      end
    end else if (r < 74) begin
      iv = a + $urandom_range(0, 2 * half);
      iv = (iv >= half) ? iv - half : 0;
      if (tps <= 1 && $urandom_range(0, 2) == 0) iv = $urandom_range(0, 40);
      if (iv > 64'hFFFF_FFFF) iv = 64'hFFFF_FFFF;
      itm.ts = gen_mark + iv[TS_BITS-1:0];
    end else if (r < 80) begin
      case ($urandom_range(0, 2))
        0:       iv = a + tps + $urandom_range(0, 1000);
        1:       iv = (a >= tps) ? a - tps - $urandom_range(0, a - tps) : a + tps;
        default: iv = a + tps - $urandom_range(0, 1);
      endcase
      if (iv > 64'hFFFF_FFFF) iv = 64'hFFFF_FFFF;
      itm.ts = gen_mark + iv[TS_BITS-1:0];
    end else if (r < 82) begin
      iv = 64'h1_0000_0000 + {$urandom_range(0, 255), $urandom};
      itm.ts = gen_mark + iv[TS_BITS-1:0];
    end else if (r < 89) begin
      itm.cmd = CMD_STOP;
      itm.ts  = gen_mark + $urandom_range(0, 1000);
    end else if (r < 92) begin
      itm.cmd = CMD_START;
      itm.ts  = gen_mark + $urandom_range(0, 1000);
    end else begin
      itm.cmd = CMD_RESET;
      if ($urandom_range(0, 3) == 0) itm.ts = gen_mark - $urandom_range(0, 5000);
      else itm.ts = gen_mark + $urandom_range(0, 5000);
    end
    // track the timeline the block will see
    case (itm.cmd)
      CMD_TICK:  if (!gen_halted) gen_mark = itm.ts;
      CMD_STOP: begin
        if (!gen_halted) begin
          gen_halted = 1'b1;
          gen_stop   = itm.ts;
        end
      end
      CMD_START: begin
        if (gen_halted) begin
          gen_halted = 1'b0;
          gen_mark   = itm.ts;
        end
      end
      default: begin
        gen_halted = 1'b0;
        gen_mark   = itm.ts;
      end
    endcase
  endtask

  task automatic run_phase(input logic [TPS_BITS-1:0] tps, input int unsigned n);
    meter_cmd_t  itm;
    int unsigned k;
    write_tps(tps);
    gen_mark   = last_stamp;
    gen_stop   = stop_stamp;
    gen_halted = halted;
    // items are made one at a time so they follow the predicted average
    for (k = 0; k < n; k++) begin
      while (command_queue.size() != 0) @(posedge clk);
      pick_command(itm);
      command_queue.push_back(itm);
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: pauses, ignored commands, outlier, saturation, wrap, extremes
    push_cmd(CMD_TICK,  48'd0);
    push_cmd(CMD_TICK,  48'd1000);
    push_cmd(CMD_TICK,  48'd2000);
    push_cmd(CMD_STOP,  48'd2500);
    push_cmd(CMD_STOP,  48'd2600);
    push_cmd(CMD_TICK,  48'd2700);
    push_cmd(CMD_START, 48'd3500);
    push_cmd(CMD_START, 48'd3600);
    push_cmd(CMD_TICK,  48'd4500);
    push_cmd(CMD_TICK,  48'd25_004_500);
    push_cmd(CMD_TICK,  48'd25_004_500 + 48'h2_0000_0000);
    push_cmd(CMD_RESET, 48'd1000);
    push_cmd(CMD_TICK,  48'd2200);
    push_cmd(CMD_TICK,  48'hFFFF_FFFF_FF00);
    push_cmd(CMD_TICK,  48'h0000_0000_0040);
    push_cmd(CMD_STOP,  48'hFFFF_FFFF_FFFF);
    push_cmd(CMD_TICK,  48'h10);
    push_cmd(CMD_START, 48'h0);
    push_cmd(CMD_RESET, 48'hFFFF_FFFF_FFFF);
    push_cmd(CMD_TICK,  48'd5);
    push_cmd(CMD_TICK,  48'd5);
    drain();

    run_phase(32'd10_000_000, 300);
    run_phase(32'd1000, 250);
    run_phase(32'd1, 120);
    run_phase(32'd0, 100);
    run_phase(32'hFFFF_FFFF, 300);
    run_phase($urandom_range(100, 5_000_000), 300);
    calm = 1'b1;
    run_phase(32'd50_000, 350);

    if (err_count == 0) begin
      $display("frame_interval_meter: match");
    end else begin
      $display("frame_interval_meter: mismatch");
    end
    $finish;
  end

endmodule
